@@ sv/roi_box_normalize_clip_core_macros.svh @@
// ----------------------------------------------------------------------------
// roi box normalize clip assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ROI_BOX_NORMALIZE_CLIP_CORE_MACROS_SVH
`define ROI_BOX_NORMALIZE_CLIP_CORE_MACROS_SVH

// antecedent implies consequent on the same edge
`define RBNC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbnc assertion failed");

// condition never holds out of reset
`define RBNC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rbnc assertion failed");

`endif

@@ sv/rbnc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbnc_pkg
// types, widths and codes of the roi box normalize clip block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbnc_pkg;

  localparam int COORD_W  = 18;
  localparam int DIFF_W   = 19;
  localparam int SIDE_W   = 29;
  localparam int EDGE_W   = 31;
  localparam int RAD_W    = 38;
  localparam int ROOT_W   = 19;
  localparam int RATIO_W  = 12;
  localparam int FRAME_W  = 13;
  localparam int MODE_W   = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // square root pipeline: steps per stage and stage count
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = 5;
  localparam int SQRT_PAIRS  = SQRT_STEPS * SQRT_STAGES;
  localparam int REM_W       = 24;

  // accept edge to result edge
  localparam int LATENCY = SQRT_STAGES + 8;

  localparam logic signed [EDGE_W-1:0] SAT_HI = EDGE_W'(131071);
  localparam logic signed [EDGE_W-1:0] SAT_LO = -EDGE_W'(131072);

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE        = 4'd0,
    MODE_WIDTH_LEN   = 4'd1,
    MODE_WIDTH_RAT   = 4'd2,
    MODE_HEIGHT_RAT  = 4'd3,
    MODE_LONG_RAT    = 4'd4,
    MODE_HEIGHT_LEN  = 4'd5,
    MODE_LONG_LEN    = 4'd6,
    MODE_LONG_SQUARE = 4'd7,
    MODE_DIAG_SQUARE = 4'd8
  } rbnc_mode_t;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RATIO  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FILTER = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [DIFF_W-1:0]  w;
    logic signed [DIFF_W-1:0]  h;
    logic signed [DIFF_W-1:0]  sx;
    logic signed [DIFF_W-1:0]  sy;
    logic signed [SIDE_W-1:0]  sw;
    logic signed [SIDE_W-1:0]  sh;
  } rbnc_box_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [EDGE_W-1:0] v
  );
    logic signed [EDGE_W-1:0] t;
    t = v;
    if (t > SAT_HI) t = SAT_HI;
    if (t < SAT_LO) t = SAT_LO;
    return t[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/rbnc_sqrt.sv @@
// ----------------------------------------------------------------------------
// rbnc_sqrt
// pipelined integer square root, four digit pairs per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbnc_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [rbnc_pkg::RAD_W-1:0]    in_rad,
  output logic                          out_vld,
  output logic [rbnc_pkg::ROOT_W-1:0]   out_root
);

  localparam int STG  = rbnc_pkg::SQRT_STAGES;
  localparam int SPS  = rbnc_pkg::SQRT_STEPS;
  localparam int NW   = 2 * rbnc_pkg::SQRT_PAIRS;
  localparam int QW   = rbnc_pkg::SQRT_PAIRS;
  localparam int RW   = rbnc_pkg::REM_W;

  logic [STG:0]    vld_r;
  logic [NW-1:0]   rad_r  [STG+1];
  logic [RW-1:0]   rem_r  [STG+1];
  logic [QW-1:0]   root_r [STG+1];

  assign vld_r[0]  = in_vld;
  assign rad_r[0]  = NW'(in_rad);
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;

  for (genvar g = 0; g < STG; g++) begin : g_stg
    logic [NW-1:0] rad_nxt;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] root_nxt;

    always_comb begin
      logic [RW-1:0] trial;
      rad_nxt  = rad_r[g];
      rem_nxt  = rem_r[g];
      root_nxt = root_r[g];
      for (int i = 0; i < SPS; i++) begin
        rem_nxt = {rem_nxt[RW-3:0], rad_nxt[NW-1:NW-2]};
        rad_nxt = {rad_nxt[NW-3:0], 2'b00};
        trial   = RW'({root_nxt, 2'b01});
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[QW-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      rad_r[g+1]  <= rad_nxt;
      rem_r[g+1]  <= rem_nxt;
      root_r[g+1] <= root_nxt;
    end
  end

  assign out_vld  = vld_r[STG];
  assign out_root = root_r[STG][rbnc_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ sv/roi_box_normalize_clip_core.sv @@
// ----------------------------------------------------------------------------
// roi_box_normalize_clip_core
// rescales a box about its center by mode, filters and clamps to the frame
// ----------------------------------------------------------------------------
// throughput: one box per cycle, busy is never raised
// the square root pipeline (5 stages) sets the depth
// synchronous active-low reset clears valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module roi_box_normalize_clip_core #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int RATIO_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbnc_pkg::ADDR_W-1:0]         paddr,
  input  logic [rbnc_pkg::DATA_W-1:0]         pwdata,
  output logic [rbnc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rbnc_pkg::COORD_W-1:0] in_x1,
  input  logic signed [rbnc_pkg::COORD_W-1:0] in_y1,
  input  logic signed [rbnc_pkg::COORD_W-1:0] in_x2,
  input  logic signed [rbnc_pkg::COORD_W-1:0] in_y2,
  output logic                                out_valid,
  output logic signed [rbnc_pkg::COORD_W-1:0] out_x1,
  output logic signed [rbnc_pkg::COORD_W-1:0] out_y1,
  output logic signed [rbnc_pkg::COORD_W-1:0] out_x2,
  output logic signed [rbnc_pkg::COORD_W-1:0] out_y2,
  output logic                                out_status
);

  localparam int DW = rbnc_pkg::DIFF_W;
  localparam int SW = rbnc_pkg::SIDE_W;
  localparam int EW = rbnc_pkg::EDGE_W;
  localparam int NS = rbnc_pkg::SQRT_STAGES;
  localparam logic signed [32:0] RHALF = 33'sd1 <<< (RATIO_FRAC_BITS - 1);

  // configuration registers
  logic [rbnc_pkg::MODE_W-1:0]  mode_r;
  logic [rbnc_pkg::RATIO_W-1:0] ratio_r;
  logic [rbnc_pkg::FRAME_W-1:0] fw_r;
  logic [rbnc_pkg::FRAME_W-1:0] fh_r;
  logic                         filt_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      ratio_r <= 12'd256;
      fw_r    <= 13'd1920;
      fh_r    <= 13'd1080;
      filt_r  <= 1'b0;
    end else if (wr_en) begin
      case (paddr[4:2])
        rbnc_pkg::REG_MODE:   mode_r  <= pwdata[rbnc_pkg::MODE_W-1:0];
        rbnc_pkg::REG_RATIO:  ratio_r <= pwdata[rbnc_pkg::RATIO_W-1:0];
        rbnc_pkg::REG_WIDTH:  fw_r    <= pwdata[rbnc_pkg::FRAME_W-1:0];
        rbnc_pkg::REG_HEIGHT: fh_r    <= pwdata[rbnc_pkg::FRAME_W-1:0];
        rbnc_pkg::REG_FILTER: filt_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rbnc_pkg::REG_MODE:   prdata = rbnc_pkg::DATA_W'(mode_r);
      rbnc_pkg::REG_RATIO:  prdata = rbnc_pkg::DATA_W'(ratio_r);
      rbnc_pkg::REG_WIDTH:  prdata = rbnc_pkg::DATA_W'(fw_r);
      rbnc_pkg::REG_HEIGHT: prdata = rbnc_pkg::DATA_W'(fh_r);
      rbnc_pkg::REG_FILTER: prdata = rbnc_pkg::DATA_W'(filt_r);
      default:              prdata = '0;
    endcase
  end

  // stage 1: capture beat
  logic                s1_vld_r;
  rbnc_pkg::rbnc_box_t s1_r, s1_nxt;

  always_comb begin
    s1_nxt    = '0;
    s1_nxt.x1 = in_x1;
    s1_nxt.y1 = in_y1;
    s1_nxt.x2 = in_x2;
    s1_nxt.y2 = in_y2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
    s1_r <= s1_nxt;
  end

  // stage 2: sides and centre sums
  logic                s2_vld_r;
  rbnc_pkg::rbnc_box_t s2_r, s2_nxt;

  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.w  = DW'(s1_r.x2) - DW'(s1_r.x1);
    s2_nxt.h  = DW'(s1_r.y2) - DW'(s1_r.y1);
    s2_nxt.sx = DW'(s1_r.x1) + DW'(s1_r.x2);
    s2_nxt.sy = DW'(s1_r.y1) + DW'(s1_r.y2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_r <= s2_nxt;
  end

  // stage 3: products
  logic                     s3_vld_r;
  rbnc_pkg::rbnc_box_t      s3_r;
  logic signed [31:0]       pw_r, ph_r;
  logic signed [37:0]       ww_r, hh_r;
  logic signed [12:0]       ratio_s;

  assign ratio_s = $signed({1'b0, ratio_r});

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_r <= s2_r;
    pw_r <= 32'(s2_r.w * ratio_s);
    ph_r <= 32'(s2_r.h * ratio_s);
    ww_r <= 38'(s2_r.w * s2_r.w);
    hh_r <= 38'(s2_r.h * s2_r.h);
  end

  // stage 4: rounded scaled sides, radicand
  logic                        s4_vld_r;
  rbnc_pkg::rbnc_box_t         s4_r, s4_nxt;
  logic [rbnc_pkg::RAD_W-1:0]  rad_r;

  always_comb begin
    logic signed [32:0] tw, th;
    tw = (33'(pw_r) + RHALF) >>> RATIO_FRAC_BITS;
    th = (33'(ph_r) + RHALF) >>> RATIO_FRAC_BITS;
    s4_nxt    = s3_r;
    s4_nxt.sw = tw[SW-1:0];
    s4_nxt.sh = th[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
    s4_r  <= s4_nxt;
    rad_r <= rbnc_pkg::RAD_W'($unsigned(ww_r + hh_r));
  end

  // square root with matching delay line
  logic                        sq_vld;
  logic [rbnc_pkg::ROOT_W-1:0] sq_root;
  rbnc_pkg::rbnc_box_t         dl_r [NS];

  rbnc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_rad   (rad_r),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  always_ff @(posedge clk) begin
    dl_r[0] <= s4_r;
    for (int i = 1; i < NS; i++) begin
      dl_r[i] <= dl_r[i-1];
    end
  end

  // stage 5: diagonal product
  logic                s5_vld_r;
  rbnc_pkg::rbnc_box_t s5_r;
  logic [30:0]         pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= sq_vld;
    s5_r <= dl_r[NS-1];
    pd_r <= 31'(sq_root * ratio_r);
  end

  // stage 6: side rules per mode
  logic                s6_vld_r;
  rbnc_pkg::rbnc_box_t s6_r;
  logic signed [SW-1:0] nw_r, nh_r, nw_nxt, nh_nxt;
  logic                rej_r, pass_r, rej_nxt, pass_nxt;

  always_comb begin
    logic signed [32:0] td;
    logic signed [SW-1:0] we, he, sd;
    logic wide;
    td   = (33'($signed({2'b00, pd_r})) + RHALF) >>> RATIO_FRAC_BITS;
    sd   = td[SW-1:0];
    we   = SW'(s5_r.w);
    he   = SW'(s5_r.h);
    wide = s5_r.w > s5_r.h;
    nw_nxt   = we;
    nh_nxt   = he;
    rej_nxt  = 1'b0;
    pass_nxt = 1'b0;
    case (rbnc_pkg::rbnc_mode_t'(mode_r))
      rbnc_pkg::MODE_NONE: ;
      rbnc_pkg::MODE_WIDTH_LEN: begin
        nw_nxt  = s5_r.sw;
        nh_nxt  = he + s5_r.sw - we;
        rej_nxt = nh_nxt <= 0;
      end
      rbnc_pkg::MODE_WIDTH_RAT, rbnc_pkg::MODE_HEIGHT_RAT,
      rbnc_pkg::MODE_LONG_RAT: begin
        nw_nxt = s5_r.sw;
        nh_nxt = s5_r.sh;
      end
      rbnc_pkg::MODE_HEIGHT_LEN: begin
        nh_nxt  = s5_r.sh;
        nw_nxt  = we + s5_r.sh - he;
        rej_nxt = nw_nxt <= 0;
      end
      rbnc_pkg::MODE_LONG_LEN: begin
        if (wide) begin
          nw_nxt  = s5_r.sw;
          nh_nxt  = he + s5_r.sw - we;
          rej_nxt = nh_nxt <= 0;
        end else begin
          nh_nxt  = s5_r.sh;
          nw_nxt  = we + s5_r.sh - he;
          rej_nxt = nw_nxt <= 0;
        end
      end
      rbnc_pkg::MODE_LONG_SQUARE: begin
        nw_nxt = wide ? s5_r.sw : s5_r.sh;
        nh_nxt = nw_nxt;
      end
      rbnc_pkg::MODE_DIAG_SQUARE: begin
        nw_nxt = sd;
        nh_nxt = sd;
      end
      default: pass_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
    s6_r   <= s5_r;
    nw_r   <= nw_nxt;
    nh_r   <= nh_nxt;
    rej_r  <= rej_nxt;
    pass_r <= pass_nxt;
  end

  // stage 7: new edges
  logic                s7_vld_r;
  rbnc_pkg::rbnc_box_t s7_r;
  logic signed [EW-1:0] a1_r, a2_r, b1_r, b2_r;
  logic                rej7_r, pass7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else        s7_vld_r <= s6_vld_r;
    s7_r    <= s6_r;
    a1_r    <= (EW'(s6_r.sx) - EW'(nw_r) + EW'(1)) >>> 1;
    a2_r    <= (EW'(s6_r.sx) + EW'(nw_r) + EW'(1)) >>> 1;
    b1_r    <= (EW'(s6_r.sy) - EW'(nh_r) + EW'(1)) >>> 1;
    b2_r    <= (EW'(s6_r.sy) + EW'(nh_r) + EW'(1)) >>> 1;
    rej7_r  <= rej_r;
    pass7_r <= pass_r;
  end

  // stage 8: filter, clamp, saturate
  logic signed [EW-1:0] fw_e, fh_e;
  logic                 frej;
  logic                 keep;
  logic signed [EW-1:0] ca1, ca2, cb1, cb2;

  assign fw_e = $signed(EW'(fw_r)) <<< COORD_FRAC_BITS;
  assign fh_e = $signed(EW'(fh_r)) <<< COORD_FRAC_BITS;
  assign frej = filt_r && (a1_r < 0 || b1_r < 0 || a2_r > fw_e || b2_r > fh_e);
  assign keep = pass7_r || rej7_r || frej;
  assign ca1  = (a1_r < 0) ? '0 : a1_r;
  assign cb1  = (b1_r < 0) ? '0 : b1_r;
  assign ca2  = (a2_r > fw_e) ? fw_e : a2_r;
  assign cb2  = (b2_r > fh_e) ? fh_e : b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s7_vld_r;
    out_status <= !pass7_r && (rej7_r || frej);
    out_x1 <= keep ? s7_r.x1 : rbnc_pkg::sat_coord(ca1);
    out_y1 <= keep ? s7_r.y1 : rbnc_pkg::sat_coord(cb1);
    out_x2 <= keep ? s7_r.x2 : rbnc_pkg::sat_coord(ca2);
    out_y2 <= keep ? s7_r.y2 : rbnc_pkg::sat_coord(cb2);
  end

endmodule

`default_nettype wire

@@ sv/rbnc_checker.sv @@
// ----------------------------------------------------------------------------
// rbnc_checker
// port level checks of beat timing on the roi box normalize clip core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "roi_box_normalize_clip_core_macros.svh"

module rbnc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `RBNC_ASSERT_NEVER(a_never_busy, busy)
  `RBNC_ASSERT_IMPL(a_beat_out, $past(start && !busy, rbnc_pkg::LATENCY), out_valid)
  `RBNC_ASSERT_IMPL(a_out_has_beat, out_valid, $past(start, rbnc_pkg::LATENCY))

endmodule

bind roi_box_normalize_clip_core rbnc_checker u_rbnc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire
